### rtl/four_level_page_table_walker_top_defines.svh
// Assertion macros for the page table walker checker.
// Each macro expects clk and rst in scope at the point of use.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_TOP_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_TOP_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define PTW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptw: same-cycle check failed");

// Consequent holds in the cycle after the antecedent.
`define PTW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ptw: next-cycle check failed");

// Consequent holds in the cycle after reset is sampled.
`define PTW_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("ptw: post-reset check failed");

`endif

### rtl/ptw_pkg.sv
// Shared types, codes and helpers of the page table walker.
// No dependencies; used by the front, queue, back and top-level modules of the block.
package ptw_pkg;

  localparam int ADDR_W = 48;
  localparam int DATA_W = 64;
  localparam int IDX_W = 9;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ACT_TRANSLATE = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [1:0] LVL0 = 2'd0;
  localparam logic [1:0] LVL1 = 2'd1;
  localparam logic [1:0] LVL2 = 2'd2;
  localparam logic [1:0] LVL3 = 2'd3;

  localparam logic [1:0] SIZE_NONE = 2'd0;

  localparam int BIT_VALID = 0;
  localparam int BIT_TABLE = 1;

  localparam logic [ADDR_W-1:0] DESC_ADDR_MASK = 48'hFFFF_FFFF_F000;

  typedef enum logic [2:0] {
    K_WALK,
    K_IDENT,
    K_WRITE,
    K_READ,
    K_NONE
  } kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_WALK
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_slot_t;

  function automatic logic [IDX_W-1:0] level_index(input logic [ADDR_W-1:0] va,
                                                   input logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      LVL0:    idx = va[47:39];
      LVL1:    idx = va[38:30];
      LVL2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  function automatic logic [ADDR_W-1:0] offset_mask(input logic [1:0] lvl);
    logic [ADDR_W-1:0] m;
    case (lvl)
      LVL1:    m = 48'h0000_3FFF_FFFF;
      LVL2:    m = 48'h0000_001F_FFFF;
      default: m = 48'h0000_0000_0FFF;
    endcase
    return m;
  endfunction

endpackage

### rtl/ptw_queue.sv
// Short request queue between the front and back parts of the walker.
// Depends on ptw_pkg for the slot type and depth.
module ptw_queue (
  input  logic             clk,
  input  logic             rst,
  input  ptw_pkg::q_slot_t push,
  input  logic             pop,
  output logic             full,
  output ptw_pkg::q_slot_t head
);

  ptw_pkg::item_t slots [ptw_pkg::QUEUE_DEPTH];
  logic [ptw_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [ptw_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [ptw_pkg::QUEUE_CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == ptw_pkg::QUEUE_CW'(ptw_pkg::QUEUE_DEPTH));
  assign do_push = push.valid && !full;
  assign do_pop = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == ptw_pkg::QUEUE_AW'(ptw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == ptw_pkg::QUEUE_AW'(ptw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/ptw_front.sv
// Front part of the walker: accepts requests and classifies them.
// Depends on ptw_pkg; feeds ptw_queue.
module ptw_front (
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [2*8*7-1:0]                s_tdata,
  input  logic [1:0]                      s_tuser,
  input  logic                            root_valid,
  input  logic                            q_full,
  output ptw_pkg::q_slot_t                push
);

  ptw_pkg::kind_t kind;

  always_comb begin
    case (s_tuser)
      ptw_pkg::ACT_TRANSLATE: kind = root_valid ? ptw_pkg::K_WALK : ptw_pkg::K_IDENT;
      ptw_pkg::ACT_WRITE:     kind = ptw_pkg::K_WRITE;
      ptw_pkg::ACT_READ:      kind = ptw_pkg::K_READ;
      default:                kind = ptw_pkg::K_NONE;
    endcase
  end

  assign s_tready = !q_full;
  assign push.valid = s_tvalid && !q_full;
  assign push.item.kind = kind;
  assign push.item.addr = s_tdata[ptw_pkg::ADDR_W-1:0];
  assign push.item.wdata = s_tdata[ptw_pkg::ADDR_W +: ptw_pkg::DATA_W];

endmodule

### rtl/ptw_back.sv
// Back part of the walker: table word store, walk sequencer, result register.
// Depends on ptw_pkg; drains ptw_queue.
module ptw_back #(
  parameter int STORE_WORDS = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [ptw_pkg::ADDR_W-1:0] root_base,
  input  ptw_pkg::q_slot_t           head,
  output logic                       pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [111:0]               m_tdata,
  output logic [2:0]                 m_tuser
);

  localparam int AW = $clog2(STORE_WORDS);

  logic [ptw_pkg::DATA_W-1:0] store [STORE_WORDS];
  logic [ptw_pkg::DATA_W-1:0] mem_q;
  logic [AW-1:0] rd_addr;
  logic mem_we;

  ptw_pkg::state_t state;
  ptw_pkg::state_t state_next;
  logic [1:0] lvl;
  logic [1:0] lvl_next;
  logic [ptw_pkg::ADDR_W-1:0] cur_addr;
  logic out_free;
  logic descend;

  logic load_out;
  logic [ptw_pkg::ADDR_W-1:0] phys_d;
  logic fault_d;
  logic [1:0] size_d;
  logic [ptw_pkg::DATA_W-1:0] rdata_d;

  logic [ptw_pkg::ADDR_W-1:0] out_phys;
  logic out_fault;
  logic [1:0] out_size;
  logic [ptw_pkg::DATA_W-1:0] out_rdata;

  assign out_free = !m_tvalid || m_tready;
  assign descend = mem_q[ptw_pkg::BIT_VALID] && (lvl != ptw_pkg::LVL3) &&
                   ((lvl == ptw_pkg::LVL0) || mem_q[ptw_pkg::BIT_TABLE]);

  always_comb begin
    state_next = state;
    case (state)
      ptw_pkg::B_IDLE: begin
        if (head.valid && out_free) begin
          if (head.item.kind == ptw_pkg::K_READ) begin
            state_next = ptw_pkg::B_READ;
          end else if (head.item.kind == ptw_pkg::K_WALK) begin
            state_next = ptw_pkg::B_WALK;
          end
        end
      end
      ptw_pkg::B_READ: state_next = ptw_pkg::B_IDLE;
      ptw_pkg::B_WALK: state_next = descend ? ptw_pkg::B_WALK : ptw_pkg::B_IDLE;
      default:         state_next = ptw_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    logic [44:0] walk_word;
    pop = 1'b0;
    mem_we = 1'b0;
    load_out = 1'b0;
    phys_d = '0;
    fault_d = 1'b0;
    size_d = ptw_pkg::SIZE_NONE;
    rdata_d = '0;
    lvl_next = lvl;
    walk_word = {root_base[ptw_pkg::ADDR_W-1:12],
                 ptw_pkg::level_index(head.item.addr, ptw_pkg::LVL0)};
    rd_addr = head.item.addr[AW+2:3];
    case (state)
      ptw_pkg::B_IDLE: begin
        if (head.valid && out_free) begin
          pop = 1'b1;
          case (head.item.kind)
            ptw_pkg::K_WRITE: begin
              mem_we = 1'b1;
              load_out = 1'b1;
            end
            ptw_pkg::K_READ: begin
              rd_addr = head.item.addr[AW+2:3];
            end
            ptw_pkg::K_WALK: begin
              rd_addr = walk_word[AW-1:0];
              lvl_next = ptw_pkg::LVL0;
            end
            ptw_pkg::K_IDENT: begin
              load_out = 1'b1;
              phys_d = head.item.addr;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ptw_pkg::B_READ: begin
        load_out = 1'b1;
        rdata_d = mem_q;
      end
      ptw_pkg::B_WALK: begin
        walk_word = {mem_q[ptw_pkg::ADDR_W-1:12],
                     ptw_pkg::level_index(cur_addr, lvl + 1'b1)};
        if (descend) begin
          rd_addr = walk_word[AW-1:0];
          lvl_next = lvl + 1'b1;
        end else if (!mem_q[ptw_pkg::BIT_VALID]) begin
          load_out = 1'b1;
          fault_d = 1'b1;
        end else begin
          load_out = 1'b1;
          phys_d = (mem_q[ptw_pkg::ADDR_W-1:0] & ptw_pkg::DESC_ADDR_MASK) |
                   (cur_addr & ptw_pkg::offset_mask(lvl));
          size_d = lvl;
        end
      end
      default: begin
        lvl_next = lvl;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[head.item.addr[AW+2:3]] <= head.item.wdata;
    end
    mem_q <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptw_pkg::B_IDLE;
      lvl <= ptw_pkg::LVL0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      lvl <= lvl_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_addr <= head.item.addr;
    end
    if (load_out) begin
      out_phys <= phys_d;
      out_fault <= fault_d;
      out_size <= size_d;
      out_rdata <= rdata_d;
    end
  end

  assign m_tdata = {out_rdata, out_phys};
  assign m_tuser = {out_size, out_fault};

endmodule

### rtl/four_level_page_table_walker_top.sv
// Top level of the four-level page table walker: configuration registers,
// front, queue and back. Depends on ptw_pkg, ptw_front, ptw_queue, ptw_back.
//
// Translates 48-bit virtual addresses through four levels of 512-entry
// descriptor tables kept in a local store of STORE_WORDS 64-bit words (a power
// of two), and writes or reads single table words. Every request gives exactly
// one result, in order. Requests enter a two-deep queue, so up to two requests
// are taken while the back part works or a result waits on the output; the
// input then drops ready until the back part takes the oldest one. The
// back part takes one request at a time from the queue: a write, an unused
// action or an identity translation is answered straight from idle, a read
// passes through the read state, and a walk visits one to four levels, each
// waiting on one registered read of the single-port table store. Table
// addresses wrap modulo the store size; a word read before it is written
// returns an arbitrary value. Write root_base and root_valid only while idle.
module four_level_page_table_walker_top #(
  parameter int STORE_WORDS = 4096
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,   // address[47:0], write_data[111:48]
  input  logic [1:0]   s_tuser,   // action[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // phys_addr[47:0], read_data[111:48]
  output logic [2:0]   m_tuser,   // fault[0], size_class[2:1]
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [47:0]  cfg_wdata
);

  localparam logic CFG_ROOT_BASE = 1'b0;

  logic [ptw_pkg::ADDR_W-1:0] root_base;
  logic root_valid;
  ptw_pkg::q_slot_t push;
  ptw_pkg::q_slot_t head;
  logic q_full;
  logic pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_base <= '0;
      root_valid <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ROOT_BASE) begin
        root_base <= cfg_wdata;
      end else begin
        root_valid <= cfg_wdata[0];
      end
    end
  end

  ptw_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .root_valid (root_valid),
    .q_full     (q_full),
    .push       (push)
  );

  ptw_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (q_full),
    .head (head)
  );

  ptw_back #(
    .STORE_WORDS (STORE_WORDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .root_base (root_base),
    .head      (head),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

### rtl/ptw_checker.sv
// Port-level checks on the walker's result stream, bound to the top level.
// Depends on four_level_page_table_walker_top_defines.svh.
`include "four_level_page_table_walker_top_defines.svh"

module ptw_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [111:0] m_tdata,
  input logic [2:0]   m_tuser
);

  `PTW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  `PTW_ASSERT_NOW(a_fault_clean, m_tvalid && m_tuser[0], m_tdata == 112'd0 && m_tuser[2:1] == 2'd0)
  `PTW_ASSERT_NOW(a_map_no_rdata, m_tvalid && m_tuser[2:1] != 2'd0, m_tdata[111:48] == 64'd0 && !m_tuser[0])
  `PTW_ASSERT_RST(a_rst_idle, !m_tvalid)

endmodule

bind four_level_page_table_walker_top ptw_checker u_ptw_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### tb/four_level_page_table_walker_checker.sv
// Checker for the page table walker: shared test constants and the result checker.
// Mirrors the table store and the root registers, predicts each result, compares.
// Depends on ptw_pkg.
`timescale 1ns / 1ps

package ptw_tb_pkg;
  import ptw_pkg::*;

  localparam int TB_STORE_WORDS = 4096;
  localparam int WORD_AW = $clog2(TB_STORE_WORDS);

  localparam logic REG_ROOT_BASE = 1'b0;
  localparam logic REG_ROOT_VALID = 1'b1;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [1:0] SIZE_1G = 2'd1;
  localparam logic [1:0] SIZE_2M = 2'd2;
  localparam logic [1:0] SIZE_4K = 2'd3;

  function automatic int store_word(input logic [47:0] byte_addr);
    return int'(byte_addr[3 +: WORD_AW]);
  endfunction

  function automatic int table_slot(input logic [47:0] base, input logic [47:0] va,
                                    input int lvl);
    logic [47:0] entry;
    entry = (base & DESC_ADDR_MASK) + {36'd0, va[39 - 9 * lvl +: 9], 3'b000};
    return store_word(entry);
  endfunction
endpackage

module four_level_page_table_walker_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [111:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [111:0] m_tdata,
  input  logic [2:0]   m_tuser,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [47:0]  cfg_wdata,
  output int           mismatches,
  output int           outstanding
);
  import ptw_pkg::*;
  import ptw_tb_pkg::*;

  typedef struct packed {
    logic [47:0] phys_addr;
    logic        fault;
    logic [1:0]  size_class;
    logic [63:0] read_data;
  } walk_result_t;

  logic [63:0]  table_words [TB_STORE_WORDS];
  logic [47:0]  root_base;
  logic         root_valid;
  walk_result_t expected_results [$];
  int           mismatch_count = 0;

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ptw mismatch on %s: got %h, expected %h", $time, field, got, want);
    mismatch_count++;
  endtask

  function automatic walk_result_t resolve_request(input logic [1:0] act,
                                                   input logic [47:0] addr);
    walk_result_t r;
    logic [47:0]  base;
    logic [63:0]  d;
    bit           done;
    int           span;
    r = '0;
    case (act)
      ACT_READ: r.read_data = table_words[store_word(addr)];
      ACT_TRANSLATE: begin
        if (!root_valid) begin
          r.phys_addr = addr;
        end else begin
          base = root_base;
          done = 1'b0;
          for (int lvl = 0; lvl < 4 && !done; lvl++) begin
            d = table_words[table_slot(base, addr, lvl)];
            if (!d[BIT_VALID]) begin
              r.fault = 1'b1;
              done = 1'b1;
            end else if (lvl == 3 || (lvl != 0 && !d[BIT_TABLE])) begin
              span = 39 - 9 * lvl;
              r.phys_addr = (d[47:0] & DESC_ADDR_MASK) | (addr & ((48'd1 << span) - 48'd1));
              r.size_class = (lvl == 1) ? SIZE_1G : (lvl == 2) ? SIZE_2M : SIZE_4K;
              done = 1'b1;
            end else begin
              base = d[47:0];
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    walk_result_t got;
    walk_result_t want;
    if (rst) begin
      root_base = '0;
      root_valid = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ROOT_BASE) root_base = cfg_wdata;
        else root_valid = cfg_wdata[0];
      end
      if (s_tvalid && s_tready) begin
        expected_results.push_back(resolve_request(s_tuser, s_tdata[47:0]));
        if (s_tuser == ACT_WRITE) table_words[store_word(s_tdata[47:0])] = s_tdata[111:48];
      end
      if (m_tvalid && m_tready) begin
        got.phys_addr = m_tdata[47:0];
        got.read_data = m_tdata[111:48];
        got.fault = m_tuser[0];
        got.size_class = m_tuser[2:1];
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request waiting", 64'(got.phys_addr), '0);
        end else begin
          want = expected_results.pop_front();
          if (got.phys_addr !== want.phys_addr)
            report_mismatch("phys_addr", 64'(got.phys_addr), 64'(want.phys_addr));
          if (got.fault !== want.fault)
            report_mismatch("fault", 64'(got.fault), 64'(want.fault));
          if (got.size_class !== want.size_class)
            report_mismatch("size_class", 64'(got.size_class), 64'(want.size_class));
          if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
        end
      end
    end
    outstanding <= expected_results.size();
    mismatches <= mismatch_count;
  end
endmodule

### tb/tb_top.sv
// Testbench top for the page table walker: clock, reset, request stimulus and verdict.
// Builds table walks on the fly, so no unwritten table word is ever read.
// Depends on ptw_pkg, ptw_tb_pkg, the checker and the walker top level.
`timescale 1ns / 1ps

module tb_top;
  import ptw_pkg::*;
  import ptw_tb_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int PHASE_ITEMS = 150;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic [1:0]   s_tuser = ACT_TRANSLATE;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         cfg_we = 1'b0;
  logic         cfg_index = REG_ROOT_BASE;
  logic [47:0]  cfg_wdata = '0;
  int           mismatches;
  int           outstanding;

  logic [63:0] shadow [TB_STORE_WORDS];
  bit          written [TB_STORE_WORDS];
  logic [47:0] root_addr = '0;
  logic        root_on = 1'b0;
  logic [47:0] last_va = '0;
  int          gap_max = 18;
  int          stall_max = 18;
  int          sent = 0;
  int          idle_cycles = 0;

  four_level_page_table_walker_top #(.STORE_WORDS(TB_STORE_WORDS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  four_level_page_table_walker_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : result_sink
    int stall;
    forever begin
      stall = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  function automatic logic [47:0] rand48();
    logic [47:0] r;
    r[47:16] = $urandom;
    r[15:0] = $urandom_range(0, 65535);
    return r;
  endfunction

  function automatic logic [47:0] word_address(input int slot);
    logic [47:0] a;
    a = rand48();
    a[3 +: WORD_AW] = slot[WORD_AW-1:0];
    return a;
  endfunction

  function automatic logic [63:0] random_desc(input int lvl);
    logic [63:0] d;
    d = {$urandom, $urandom};
    d[BIT_VALID] = ($urandom_range(0, 99) < 88);
    if (lvl == 1 || lvl == 2) d[BIT_TABLE] = ($urandom_range(0, 99) < 70);
    return d;
  endfunction

  function automatic logic [47:0] next_va();
    logic [47:0] va;
    va = rand48();
    if ($urandom_range(0, 9) < 4)
      va = $urandom_range(0, 1) ? {last_va[47:30], va[29:0]} : {last_va[47:21], va[20:0]};
    last_va = va;
    return va;
  endfunction

  // First table word on the walk of va that has not been written yet, or -1.
  function automatic int first_hole(input logic [47:0] va, output int lvl);
    logic [47:0] base;
    int          slot;
    int          hole;
    bit          going;
    hole = -1;
    lvl = 0;
    base = root_addr;
    going = root_on;
    for (int l = 0; l < 4 && going; l++) begin
      slot = table_slot(base, va, l);
      lvl = l;
      if (!written[slot]) begin
        hole = slot;
        going = 1'b0;
      end else if (!shadow[slot][BIT_VALID] || l == 3 ||
                   (l != 0 && !shadow[slot][BIT_TABLE])) begin
        going = 1'b0;
      end else begin
        base = shadow[slot][47:0];
      end
    end
    return hole;
  endfunction

  task automatic send_request(input logic [1:0] act, input logic [47:0] addr,
                              input logic [63:0] wd);
    int gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {wd, addr};
    do @(posedge clk); while (!s_tready);
    if (act == ACT_WRITE) begin
      shadow[store_word(addr)] = wd;
      written[store_word(addr)] = 1'b1;
    end
    sent++;
  endtask

  // Hold off new requests until every result is back.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic configure(input logic [47:0] base, input logic valid);
    cfg_we <= 1'b1;
    cfg_index <= REG_ROOT_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= REG_ROOT_VALID;
    cfg_wdata <= {47'd0, valid};
    @(posedge clk);
    cfg_we <= 1'b0;
    root_addr = base;
    root_on = valid;
  endtask

  task automatic walk_case(input logic [47:0] va, input logic [63:0] d0, input logic [63:0] d1,
                           input logic [63:0] d2, input logic [63:0] d3, input int levels);
    logic [47:0] base;
    logic [63:0] descs [4];
    descs = '{d0, d1, d2, d3};
    base = root_addr;
    for (int l = 0; l < levels; l++) begin
      send_request(ACT_WRITE, word_address(table_slot(base, va, l)), descs[l]);
      base = descs[l][47:0];
    end
    send_request(ACT_TRANSLATE, va, '0);
  endtask

  // Fill every missing table word on the path with a random descriptor, then translate.
  task automatic map_and_translate(input logic [47:0] va);
    int hole;
    int lvl;
    hole = first_hole(va, lvl);
    while (hole >= 0) begin
      send_request(ACT_WRITE, word_address(hole), random_desc(lvl));
      hole = first_hole(va, lvl);
    end
    send_request(ACT_TRANSLATE, va, {$urandom, $urandom});
  endtask

  task automatic read_back();
    int slot;
    do slot = $urandom_range(0, TB_STORE_WORDS - 1); while (!written[slot]);
    send_request(ACT_READ, word_address(slot), {$urandom, $urandom});
  endtask

  initial begin : stimulus
    int          pick;
    int          quota;
    int          lvl;
    logic [47:0] va;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(ACT_TRANSLATE, '0, '0);
    send_request(ACT_TRANSLATE, '1, '1);
    send_request(ACT_UNUSED, '1, '1);
    send_request(ACT_WRITE, '1, '1);
    send_request(ACT_READ, 48'h0000_0000_7FF8, '0);
    send_request(ACT_WRITE, '0, '0);
    send_request(ACT_READ, 48'hFFFF_FFFF_8000, '1);
    send_request(ACT_UNUSED, '0, '0);
    drain();
    configure('1, 1'b1);
    walk_case(48'h0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFE, '0, '0, '0, 1);
    walk_case(48'h0080_4030_2ABC, 64'hFFFF_0000_0000_1003, 64'h0000_1234_4000_0FFD,
              '0, '0, 2);
    walk_case(48'h7FFF_FFE0_1234, 64'h0000_0000_0000_2001, 64'h0000_0000_0000_3003,
              64'hFFFF_ABCD_EF00_0001, '0, 3);
    walk_case('1, 64'h0000_0000_0000_4003, 64'h0000_0000_0000_5003,
              64'h0000_0000_0000_6003, 64'hFFFF_FFFF_FFFF_FFFD, 4);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: configure(rand48() & DESC_ADDR_MASK, 1'b1);
        1: configure('0, 1'b1);
        2: configure('1, 1'b1);
        3: configure(rand48(), 1'b0);
        default: configure(rand48(), 1'b1);
      endcase
      gap_max = (ph % 3 == 1) ? 0 : 18;
      stall_max = (ph % 3 == 2) ? 0 : 18;
      quota = sent + PHASE_ITEMS;
      while (sent < quota) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          map_and_translate(next_va());
        end else if (pick < 77) begin
          read_back();
        end else if (pick < 88) begin
          send_request(ACT_WRITE, rand48(), {$urandom, $urandom});
        end else if (pick < 93) begin
          send_request(ACT_UNUSED, rand48(), {$urandom, $urandom});
        end else if (pick < 95) begin
          drain();
        end else begin
          va = rand48();
          if (first_hole(va, lvl) < 0) send_request(ACT_TRANSLATE, va, {$urandom, $urandom});
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
